// File: sv/ggx_pkg.sv
// ----------------------------------------------------------------------------
// GGX specular package
// Shared types, register indexes and fixed-point constants of the GGX block.
// ----------------------------------------------------------------------------
package ggx_pkg;

    typedef logic signed [15:0] t_cosine;
    typedef logic [31:0]        t_spec;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_REFL = 2'd1;

    localparam logic [CFG_DATA_W-1:0] ROUGHNESS_RST = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] BASE_REFL_RST = 16'd1311;

    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] ALPHA_FLOOR = 32'd429497;
    localparam logic [31:0] INV_PI_Q32  = 32'd1367130551;
    localparam logic [33:0] DEN4_FLOOR  = 34'd43;

    localparam int MUL_LAT  = 2;
    localparam int SQRT_LAT = 32;

endpackage

// File: sv/ggx_smp_if.sv
// ----------------------------------------------------------------------------
// GGX sample channel
// Valid/ready channel carrying the four signed Q1.15 cosines of one sample.
// ----------------------------------------------------------------------------
interface ggx_smp_if;
    logic             valid;
    logic             ready;
    ggx_pkg::t_cosine n_dot_l;
    ggx_pkg::t_cosine n_dot_v;
    ggx_pkg::t_cosine n_dot_h;
    ggx_pkg::t_cosine v_dot_h;

    modport source (output valid, output n_dot_l, output n_dot_v, output n_dot_h,
                    output v_dot_h, input ready);
    modport sink   (input valid, input n_dot_l, input n_dot_v, input n_dot_h,
                    input v_dot_h, output ready);
endinterface

// File: sv/ggx_res_if.sv
// ----------------------------------------------------------------------------
// GGX result channel
// Valid/ready channel carrying the Q16.16 specular value and its overflow flag.
// ----------------------------------------------------------------------------
interface ggx_res_if;
    logic           valid;
    logic           ready;
    ggx_pkg::t_spec specular;
    logic           saturated;

    modport source (output valid, output specular, output saturated, input ready);
    modport sink   (input valid, input specular, input saturated, output ready);
endinterface

// File: sv/ggx_mul.sv
// ----------------------------------------------------------------------------
// GGX Q32 multiplier
// Two-stage Q32 product: 32x32 partial products, then sum, round half up
// and saturate to 64 bits.
// ----------------------------------------------------------------------------
module ggx_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [63:0]   o_p
);
    logic [63:0]  a_ext;
    logic [63:0]  b_ext;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic [127:0] n_sum;
    logic [63:0]  r_p;

    assign a_ext = 64'(i_a);
    assign b_ext = 64'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= a_ext[31:0] * b_ext[31:0];
            r_lh <= a_ext[31:0] * b_ext[63:32];
            r_hl <= a_ext[63:32] * b_ext[31:0];
            r_hh <= a_ext[63:32] * b_ext[63:32];
        end
    end

    assign n_sum = {64'h0, r_ll} + {32'h0, r_lh, 32'h0} + {32'h0, r_hl, 32'h0}
                 + {r_hh, 64'h0} + 128'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (|n_sum[127:96]) ? '1 : n_sum[95:32];
        end
    end

    assign o_p = r_p;
endmodule

// File: sv/ggx_div.sv
// ----------------------------------------------------------------------------
// GGX Q32 divider
// Restoring divider, one quotient bit per stage: floor(n * 2^32 / d),
// saturated to 64 bits with an overflow flag.
// ----------------------------------------------------------------------------
module ggx_div #(
    parameter int NW = 32,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [63:0]   o_quo,
    output logic          o_ovf
);
    localparam int QB = NW + 32;

    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_quo [QB];
    logic [NW-1:0] r_num [QB];
    logic [DW-1:0] r_den [QB];
    logic [DW-1:0] n_rem [QB];
    logic [QB-1:0] n_quo [QB];
    logic [NW-1:0] n_num [QB];
    logic [DW-1:0] n_den [QB];

    always_comb begin
        logic [DW:0]   trial;
        logic          take;
        logic [DW-1:0] rem;
        logic [QB-1:0] quo;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        rem = '0;
        quo = '0;
        num = i_num;
        den = i_den;
        for (int k = 0; k < QB; k++) begin
            trial    = {rem, num[NW-1]};
            take     = trial >= {1'b0, den};
            n_rem[k] = take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
            n_quo[k] = {quo[QB-2:0], take};
            n_num[k] = {num[NW-2:0], 1'b0};
            n_den[k] = den;
            rem      = r_rem[k];
            quo      = r_quo[k];
            num      = r_num[k];
            den      = r_den[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    generate
        if (QB > 64) begin : g_wide
            assign o_ovf = |r_quo[QB-1][QB-1:64];
            assign o_quo = o_ovf ? '1 : r_quo[QB-1][63:0];
        end else begin : g_narrow
            assign o_ovf = 1'b0;
            assign o_quo = 64'(r_quo[QB-1]);
        end
    endgenerate
endmodule

// File: sv/ggx_specular_brdf.sv
// ----------------------------------------------------------------------------
// GGX specular BRDF
// Samples arrive on i_smp as four signed Q1.15 cosines (N.L, N.V, N.H, V.H);
// results leave on o_res as an unsigned Q16.16 specular value with a
// saturation flag. A beat moves when valid and ready are both high.
// Roughness and base reflectance are written through i_cfg_we/i_cfg_idx/
// i_cfg_wdata; the user must do so only while no sample is in flight, as the
// block itself does not enforce it. The pipeline takes one beat per cycle
// while o_res is not stalled. Its depth is set by the distribution path:
// input register, five two-stage multipliers, the 64-, 96- and 96-stage
// bit-per-stage dividers and the output register.
// When o_res is stalled with a result waiting, the whole pipeline holds and
// i_smp.ready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads roughness 0.5 and reflectance 1311.
// ----------------------------------------------------------------------------
module ggx_specular_brdf #(
    parameter int COSINE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ggx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ggx_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    ggx_smp_if.sink                           i_smp,
    ggx_res_if.source                         o_res
);
    import ggx_pkg::*;

    localparam int CUT = (COSINE_BITS >= 15) ? 0 : 15 - COSINE_BITS;
    localparam logic [14:0] COS_MASK = 15'(15'h7FFF << CUT);

    localparam int P_IN   = 1;
    localparam int P_A    = P_IN + MUL_LAT;
    localparam int P_B    = P_A + MUL_LAT;
    localparam int P_FR   = P_B + 2 * MUL_LAT;
    localparam int P_Q1   = P_B + 32 + 32;
    localparam int P_SQ   = P_B + SQRT_LAT;
    localparam int P_G1   = P_SQ + 33 + 32;
    localparam int P_G    = P_G1 + MUL_LAT;
    localparam int P_Q2   = P_Q1 + 64 + 32;
    localparam int P_DIST = P_Q2 + MUL_LAT;
    localparam int P_N1   = P_DIST + MUL_LAT;
    localparam int P_NUM  = P_N1 + MUL_LAT;
    localparam int P_RES  = P_NUM + 64 + 32;
    localparam int P_OUT  = P_RES + 1;
    localparam int SQ_LANES = 2;

    function automatic logic [31:0] cos_q32(input logic [15:0] raw);
        return raw[15] ? 32'h0 : {raw[14:0] & COS_MASK, 17'h0};
    endfunction

    logic [CFG_DATA_W-1:0] r_roughness;
    logic [CFG_DATA_W-1:0] r_base_refl;
    logic [P_OUT-1:0]      r_vld;
    logic                  adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roughness <= ROUGHNESS_RST;
            r_base_refl <= BASE_REFL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROUGHNESS: r_roughness <= i_cfg_wdata;
                REG_BASE_REFL: r_base_refl <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv         = !r_vld[P_OUT-1] || o_res.ready;
    assign i_smp.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[P_OUT-2:0], i_smp.valid};
        end
    end

    // input stage
    logic [31:0] n_nl, n_nv, n_nh, n_vh, n_alpha;
    logic [31:0] r_nl, r_nv, r_nh, r_vh, r_alpha;
    logic        r_zero;

    assign n_nl    = cos_q32(i_smp.n_dot_l);
    assign n_nv    = cos_q32(i_smp.n_dot_v);
    assign n_nh    = cos_q32(i_smp.n_dot_h);
    assign n_vh    = cos_q32(i_smp.v_dot_h);
    assign n_alpha = r_roughness * r_roughness;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nl    <= n_nl;
            r_nv    <= n_nv;
            r_nh    <= n_nh;
            r_vh    <= n_vh;
            r_zero  <= (n_nl == 32'h0) || (n_nv == 32'h0);
            r_alpha <= (n_alpha < ALPHA_FLOOR) ? ALPHA_FLOOR : n_alpha;
        end
    end

    logic [32:0] om;
    assign om = ONE_Q32 - {1'b0, r_vh};

    logic [63:0] a2_p, nh2_p, l2_p, v2_p, lv_p, om2_p;

    ggx_mul #(.AW(32), .BW(32)) u_mul_a2  (.i_clk, .i_en(adv), .i_a(r_alpha), .i_b(r_alpha),
                                           .o_p(a2_p));
    ggx_mul #(.AW(32), .BW(32)) u_mul_nh2 (.i_clk, .i_en(adv), .i_a(r_nh), .i_b(r_nh),
                                           .o_p(nh2_p));
    ggx_mul #(.AW(32), .BW(32)) u_mul_l2  (.i_clk, .i_en(adv), .i_a(r_nl), .i_b(r_nl),
                                           .o_p(l2_p));
    ggx_mul #(.AW(32), .BW(32)) u_mul_v2  (.i_clk, .i_en(adv), .i_a(r_nv), .i_b(r_nv),
                                           .o_p(v2_p));
    ggx_mul #(.AW(32), .BW(32)) u_mul_lv  (.i_clk, .i_en(adv), .i_a(r_nl), .i_b(r_nv),
                                           .o_p(lv_p));
    ggx_mul #(.AW(33), .BW(33)) u_mul_om2 (.i_clk, .i_en(adv), .i_a(om), .i_b(om),
                                           .o_p(om2_p));

    // stage A
    logic [32:0] oma2;
    logic [33:0] n_den4;
    assign oma2   = ONE_Q32 - {1'b0, a2_p[31:0]};
    assign n_den4 = ({lv_p[31:0], 2'b00} < DEN4_FLOOR) ? DEN4_FLOOR : {lv_p[31:0], 2'b00};

    logic [63:0] t_p, sl_p, sv_p, om4_p;

    ggx_mul #(.AW(32), .BW(33)) u_mul_t   (.i_clk, .i_en(adv), .i_a(nh2_p[31:0]), .i_b(oma2),
                                           .o_p(t_p));
    ggx_mul #(.AW(32), .BW(33)) u_mul_sl  (.i_clk, .i_en(adv), .i_a(l2_p[31:0]), .i_b(oma2),
                                           .o_p(sl_p));
    ggx_mul #(.AW(32), .BW(33)) u_mul_sv  (.i_clk, .i_en(adv), .i_a(v2_p[31:0]), .i_b(oma2),
                                           .o_p(sv_p));
    ggx_mul #(.AW(33), .BW(33)) u_mul_om4 (.i_clk, .i_en(adv), .i_a(om2_p[32:0]),
                                           .i_b(om2_p[32:0]), .o_p(om4_p));

    // delay lines
    logic [32:0] r_om_dly   [P_B - P_IN];
    logic [31:0] r_a2_dly   [P_B - P_A];
    logic [33:0] r_den4_dly [P_NUM - P_A];
    logic [63:0] r_x_dly    [P_SQ - P_IN];
    logic [32:0] r_den_dly  [P_Q1 - P_B];
    logic [33:0] r_fres_dly [P_N1 - P_FR];
    logic [63:0] r_g_dly    [P_DIST - P_G];
    logic        r_zero_dly [P_RES - P_IN];

    logic [32:0] den;
    logic [33:0] fres;
    logic [63:0] g_p;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_om_dly[0]   <= om;
            r_a2_dly[0]   <= a2_p[31:0];
            r_den4_dly[0] <= n_den4;
            r_x_dly[0]    <= {r_nl, r_nv};
            r_den_dly[0]  <= den;
            r_fres_dly[0] <= fres;
            r_g_dly[0]    <= g_p;
            r_zero_dly[0] <= r_zero;
            for (int k = 1; k < P_B - P_IN; k++) r_om_dly[k] <= r_om_dly[k-1];
            for (int k = 1; k < P_B - P_A; k++) r_a2_dly[k] <= r_a2_dly[k-1];
            for (int k = 1; k < P_NUM - P_A; k++) r_den4_dly[k] <= r_den4_dly[k-1];
            for (int k = 1; k < P_SQ - P_IN; k++) r_x_dly[k] <= r_x_dly[k-1];
            for (int k = 1; k < P_Q1 - P_B; k++) r_den_dly[k] <= r_den_dly[k-1];
            for (int k = 1; k < P_N1 - P_FR; k++) r_fres_dly[k] <= r_fres_dly[k-1];
            for (int k = 1; k < P_DIST - P_G; k++) r_g_dly[k] <= r_g_dly[k-1];
            for (int k = 1; k < P_RES - P_IN; k++) r_zero_dly[k] <= r_zero_dly[k-1];
        end
    end

    // stage B
    logic [31:0] a2_b;
    logic [32:0] sq_in [SQ_LANES];
    assign a2_b     = r_a2_dly[P_B - P_A - 1];
    assign den      = ONE_Q32 - {1'b0, t_p[31:0]};
    assign sq_in[0] = {1'b0, a2_b} + {1'b0, sl_p[31:0]};
    assign sq_in[1] = {1'b0, a2_b} + {1'b0, sv_p[31:0]};

    // Fresnel
    logic [63:0] om5_p, fr_p;
    logic [32:0] f0;
    logic [32:0] omf0;
    assign f0   = {1'b0, r_base_refl, 16'h0};
    assign omf0 = ONE_Q32 - f0;
    assign fres = {1'b0, f0} + {1'b0, fr_p[32:0]};

    ggx_mul #(.AW(33), .BW(33)) u_mul_om5 (.i_clk, .i_en(adv), .i_a(om4_p[32:0]),
                                           .i_b(r_om_dly[P_B - P_IN - 1]), .o_p(om5_p));
    ggx_mul #(.AW(33), .BW(33)) u_mul_fr  (.i_clk, .i_en(adv), .i_a(omf0), .i_b(om5_p[32:0]),
                                           .o_p(fr_p));

    // distribution
    logic [63:0] q1_q, q2_q, dist_p;

    ggx_div #(.NW(32), .DW(33)) u_div_q1 (.i_clk, .i_en(adv), .i_num(a2_b), .i_den(den),
                                          .o_quo(q1_q), .o_ovf());
    ggx_div #(.NW(64), .DW(33)) u_div_q2 (.i_clk, .i_en(adv), .i_num(q1_q),
                                          .i_den(r_den_dly[P_Q1 - P_B - 1]),
                                          .o_quo(q2_q), .o_ovf());
    ggx_mul #(.AW(64), .BW(32)) u_mul_dist (.i_clk, .i_en(adv), .i_a(q2_q), .i_b(INV_PI_Q32),
                                            .o_p(dist_p));

    // square root, two bits of radicand per stage
    logic [33:0] r_sq_rem  [SQ_LANES][SQRT_LAT];
    logic [31:0] r_sq_root [SQ_LANES][SQRT_LAT];
    logic [31:0] r_sq_rad  [SQ_LANES][SQRT_LAT];
    logic        r_sq_big  [SQ_LANES][SQRT_LAT];
    logic [33:0] n_sq_rem  [SQ_LANES][SQRT_LAT];
    logic [31:0] n_sq_root [SQ_LANES][SQRT_LAT];
    logic [31:0] n_sq_rad  [SQ_LANES][SQRT_LAT];
    logic        n_sq_big  [SQ_LANES][SQRT_LAT];

    always_comb begin
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] rad;
        logic        big;
        logic [35:0] trial;
        logic [35:0] tst;
        for (int l = 0; l < SQ_LANES; l++) begin
            rem  = '0;
            root = '0;
            rad  = sq_in[l][31:0];
            big  = sq_in[l][32];
            for (int k = 0; k < SQRT_LAT; k++) begin
                trial = {rem, rad[31:30]};
                tst   = {2'b00, root, 2'b01};
                if (trial >= tst) begin
                    n_sq_rem[l][k]  = 34'(trial - tst);
                    n_sq_root[l][k] = {root[30:0], 1'b1};
                end else begin
                    n_sq_rem[l][k]  = trial[33:0];
                    n_sq_root[l][k] = {root[30:0], 1'b0};
                end
                n_sq_rad[l][k] = {rad[29:0], 2'b00};
                n_sq_big[l][k] = big;
                rem  = r_sq_rem[l][k];
                root = r_sq_root[l][k];
                rad  = r_sq_rad[l][k];
                big  = r_sq_big[l][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_sq_rad  <= n_sq_rad;
            r_sq_big  <= n_sq_big;
        end
    end

    // Smith G1 for both cosines
    logic [31:0] x_sq [SQ_LANES];
    logic [32:0] sq   [SQ_LANES];
    logic [63:0] g1_q [SQ_LANES];

    assign x_sq[0] = r_x_dly[P_SQ - P_IN - 1][63:32];
    assign x_sq[1] = r_x_dly[P_SQ - P_IN - 1][31:0];

    generate
        for (genvar l = 0; l < SQ_LANES; l++) begin : g_g1
            assign sq[l] = r_sq_big[l][SQRT_LAT-1] ? ONE_Q32
                                                    : {1'b0, r_sq_root[l][SQRT_LAT-1]};
            ggx_div #(.NW(33), .DW(34)) u_div_g1 (
                .i_clk,
                .i_en  (adv),
                .i_num ({x_sq[l], 1'b0}),
                .i_den ({2'b00, x_sq[l]} + {1'b0, sq[l]}),
                .o_quo (g1_q[l]),
                .o_ovf ()
            );
        end
    endgenerate

    ggx_mul #(.AW(64), .BW(64)) u_mul_g (.i_clk, .i_en(adv), .i_a(g1_q[0]), .i_b(g1_q[1]),
                                         .o_p(g_p));

    // numerator and final quotient
    logic [63:0] n1_p, num_p, res_q;
    logic        res_ovf;

    ggx_mul #(.AW(64), .BW(64)) u_mul_n1  (.i_clk, .i_en(adv), .i_a(dist_p),
                                           .i_b(r_g_dly[P_DIST - P_G - 1]), .o_p(n1_p));
    ggx_mul #(.AW(64), .BW(34)) u_mul_num (.i_clk, .i_en(adv), .i_a(n1_p),
                                           .i_b(r_fres_dly[P_N1 - P_FR - 1]), .o_p(num_p));
    ggx_div #(.NW(64), .DW(34)) u_div_res (.i_clk, .i_en(adv), .i_num(num_p),
                                           .i_den(r_den4_dly[P_NUM - P_A - 1]),
                                           .o_quo(res_q), .o_ovf(res_ovf));

    // round to Q16.16 and saturate; force zero when N.L or N.V clamps to zero
    logic [48:0] n_r16;
    logic        n_sat;
    logic        zero_res;
    t_spec       r_spec;
    logic        r_sat;

    assign n_r16    = {1'b0, res_q[63:16]} + 49'(res_q[15]);
    assign n_sat    = res_ovf || (|n_r16[48:32]);
    assign zero_res = r_zero_dly[P_RES - P_IN - 1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_spec <= zero_res ? '0 : (n_sat ? '1 : n_r16[31:0]);
            r_sat  <= !zero_res && n_sat;
        end
    end

    assign o_res.valid     = r_vld[P_OUT-1];
    assign o_res.specular  = r_spec;
    assign o_res.saturated = r_sat;

`ifndef SYNTH
    a_sat_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.saturated |-> o_res.specular == '1)
        else $error("saturated result without all-ones value");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_smp.ready)
        else $error("sample taken while result stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif
endmodule
